// ----- sv/gete_pkg.sv -----
package gete_pkg;

   localparam int ENTRIES_DEF   = 64;
   localparam int KEY_BITS_DEF  = 16;
   localparam int KEY_PORT_BITS = 16;
   localparam int KIND_BITS     = 3;
   localparam int STATUS_BITS   = 2;
   localparam int COUNT_BITS    = 7;
   localparam int MAX_RESULTS   = 64;
   // power of two, so the queue pointers wrap on their own
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [KIND_BITS-1:0] KIND_ADD_NODE = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_ADD_EDGE = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_DEL_NODE = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_DEGREE   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_EXISTS   = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_LIST     = 3'd5;

   localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_DUP  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd2;

   typedef enum logic [2:0] {
      OP_ADD_NODE,
      OP_ADD_EDGE,
      OP_DEL_NODE,
      OP_DEGREE,
      OP_EXISTS,
      OP_LIST,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type                   op;
      logic [KEY_PORT_BITS-1:0] src_key;
      logic [KEY_PORT_BITS-1:0] dest_key;
   } item_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]   status;
      logic                     found;
      logic [COUNT_BITS-1:0]    count;
      logic [KEY_PORT_BITS-1:0] edge_src;
      logic [KEY_PORT_BITS-1:0] edge_dest;
      logic                     last;
   } rsp_type;

endpackage

// ----- sv/gete_front.sv -----
module gete_front #(
   parameter int KEY_BITS = gete_pkg::KEY_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [gete_pkg::KIND_BITS-1:0]       req_kind,
   input  logic [gete_pkg::KEY_PORT_BITS-1:0]   req_src_key,
   input  logic [gete_pkg::KEY_PORT_BITS-1:0]   req_dest_key,
   output logic                                 q_valid,
   output gete_pkg::item_type                   q_item,
   input  logic                                 q_pop
);

   localparam int PB = gete_pkg::KEY_PORT_BITS;
   localparam int KW = (KEY_BITS < PB) ? KEY_BITS : PB;
   localparam int QD = gete_pkg::QUEUE_DEPTH;
   localparam int PW = (QD > 1) ? $clog2(QD) : 1;
   localparam int CW = $clog2(QD + 1);
   localparam logic [PB-1:0] KEY_MASK = {PB{1'b1}} >> (PB - KW);

   gete_pkg::item_type item_in;
   gete_pkg::item_type q_ff [QD];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               push;
   logic               pop;

   assign busy    = (cnt_ff == CW'(QD));
   assign q_valid = (cnt_ff != '0);
   assign q_item  = q_ff[rd_ptr_ff];
   assign push    = start & ~busy;
   assign pop     = q_pop & q_valid;

   // classify the request and trim keys to the compared width
   always_comb begin
      item_in.src_key  = req_src_key & KEY_MASK;
      item_in.dest_key = req_dest_key & KEY_MASK;
      unique case (req_kind)
         gete_pkg::KIND_ADD_NODE: item_in.op = gete_pkg::OP_ADD_NODE;
         gete_pkg::KIND_ADD_EDGE: item_in.op = gete_pkg::OP_ADD_EDGE;
         gete_pkg::KIND_DEL_NODE: item_in.op = gete_pkg::OP_DEL_NODE;
         gete_pkg::KIND_DEGREE:   item_in.op = gete_pkg::OP_DEGREE;
         gete_pkg::KIND_EXISTS:   item_in.op = gete_pkg::OP_EXISTS;
         gete_pkg::KIND_LIST:     item_in.op = gete_pkg::OP_LIST;
         default:                 item_in.op = gete_pkg::OP_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + CW'(1);
         2'b01:   cnt_in = cnt_ff - CW'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ----- sv/gete_back.sv -----
module gete_back #(
   parameter int ENTRIES  = gete_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = gete_pkg::KEY_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  gete_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   output gete_pkg::rsp_type  rsp
);

   localparam int PB = gete_pkg::KEY_PORT_BITS;
   localparam int KW = (KEY_BITS < PB) ? KEY_BITS : PB;
   localparam int IW = $clog2(ENTRIES);
   localparam int WW = 2 + 2 * KW;
   localparam int LW = $clog2(gete_pkg::MAX_RESULTS + 1);
   localparam int CB = gete_pkg::COUNT_BITS;
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   // word layout: valid, has_dest, source key, target key
   logic [WW-1:0] mem [ENTRIES];
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   logic [WW-1:0] mem_wdata;
   logic [WW-1:0] rd_data_ff;

   gete_pkg::state_type state_ff, state_in;
   gete_pkg::item_type  cur_ff, cur_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                chk_valid_ff, chk_valid_in;
   logic [IW-1:0]       chk_idx_ff, chk_idx_in;
   logic                free_found_ff, free_found_in;
   logic [IW-1:0]       free_idx_ff, free_idx_in;
   logic                dup_ff, dup_in;
   logic [CB-1:0]       cnt_ff, cnt_in;
   logic [LW-1:0]       list_n_ff, list_n_in;
   logic                pend_ff, pend_in;
   logic [KW-1:0]       pend_src_ff, pend_src_in;
   logic [KW-1:0]       pend_dest_ff, pend_dest_in;
   logic                rsp_valid_ff, rsp_valid_in;
   gete_pkg::rsp_type   rsp_ff, rsp_in;

   logic          e_v;
   logic          e_hd;
   logic [KW-1:0] e_src;
   logic [KW-1:0] e_dst;
   logic [KW-1:0] s_k;
   logic [KW-1:0] d_k;
   logic          src_m;
   logic          dst_m;
   logic          pair_m;

   assign e_v    = rd_data_ff[WW-1];
   assign e_hd   = rd_data_ff[WW-2];
   assign e_src  = rd_data_ff[2*KW-1:KW];
   assign e_dst  = rd_data_ff[KW-1:0];
   assign s_k    = cur_ff.src_key[KW-1:0];
   assign d_k    = cur_ff.dest_key[KW-1:0];
   assign src_m  = (e_src == s_k);
   assign dst_m  = (e_dst == s_k);
   assign pair_m = e_v & e_hd & src_m & (e_dst == d_k);

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gete_pkg::ST_CLEAR;
         idx_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      chk_idx_ff    <= chk_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      dup_ff        <= dup_in;
      cnt_ff        <= cnt_in;
      list_n_ff     <= list_n_in;
      pend_ff       <= pend_in;
      pend_src_ff   <= pend_src_in;
      pend_dest_ff  <= pend_dest_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      dup_in        = dup_ff;
      cnt_in        = cnt_ff;
      list_n_in     = list_n_ff;
      pend_in       = pend_ff;
      pend_src_in   = pend_src_ff;
      pend_dest_in  = pend_dest_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = chk_idx_ff;
      mem_wdata     = {1'b0, rd_data_ff[WW-2:0]};

      unique case (state_ff)
         gete_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = '0;
            idx_in    = idx_ff + IW'(1);
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = gete_pkg::ST_IDLE;
            end
         end
         gete_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               cur_in        = q_item;
               idx_in        = '0;
               free_found_in = 1'b0;
               dup_in        = 1'b0;
               cnt_in        = '0;
               list_n_in     = '0;
               pend_in       = 1'b0;
               state_in      = gete_pkg::ST_SCAN;
            end
         end
         gete_pkg::ST_SCAN: begin
            chk_valid_in = 1'b1;
            chk_idx_in   = idx_ff;
            idx_in       = idx_ff + IW'(1);
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = gete_pkg::ST_DRAIN;
            end
         end
         gete_pkg::ST_DRAIN: begin
            state_in = gete_pkg::ST_DONE;
         end
         gete_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            unique case (cur_ff.op)
               gete_pkg::OP_ADD_NODE: begin
                  if (free_found_ff) begin
                     mem_we        = 1'b1;
                     mem_waddr     = free_idx_ff;
                     mem_wdata     = {1'b1, 1'b0, s_k, {KW{1'b0}}};
                     rsp_in.status = gete_pkg::STATUS_OK;
                  end else begin
                     rsp_in.status = gete_pkg::STATUS_FULL;
                  end
               end
               gete_pkg::OP_ADD_EDGE: begin
                  if (dup_ff) begin
                     rsp_in.status = gete_pkg::STATUS_DUP;
                  end else if (free_found_ff) begin
                     mem_we        = 1'b1;
                     mem_waddr     = free_idx_ff;
                     mem_wdata     = {1'b1, 1'b1, s_k, d_k};
                     rsp_in.status = gete_pkg::STATUS_OK;
                  end else begin
                     rsp_in.status = gete_pkg::STATUS_FULL;
                  end
               end
               gete_pkg::OP_DEGREE: begin
                  rsp_in.count = cnt_ff;
               end
               gete_pkg::OP_EXISTS: begin
                  rsp_in.found = dup_ff;
               end
               gete_pkg::OP_LIST: begin
                  if (pend_ff) begin
                     rsp_in.found     = 1'b1;
                     rsp_in.edge_src  = PB'(pend_src_ff);
                     rsp_in.edge_dest = PB'(pend_dest_ff);
                  end
               end
               default: ;
            endcase
            state_in = gete_pkg::ST_IDLE;
         end
         default: begin
            state_in = gete_pkg::ST_IDLE;
         end
      endcase

      // one table entry per cycle, in slot order
      if (chk_valid_ff) begin
         if (!e_v && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_idx_ff;
         end
         if (pair_m) begin
            dup_in = 1'b1;
         end
         unique case (cur_ff.op)
            gete_pkg::OP_DEL_NODE: begin
               if (e_v && (src_m || (e_hd && dst_m))) begin
                  mem_we = 1'b1;
               end
            end
            gete_pkg::OP_DEGREE: begin
               if (e_v && e_hd && src_m && (cnt_ff != gete_pkg::COUNT_MAX)) begin
                  cnt_in = cnt_ff + CB'(1);
               end
            end
            gete_pkg::OP_LIST: begin
               // hold one match back so the final one can carry the last mark
               if (e_v && e_hd && (src_m || dst_m) &&
                   (list_n_ff != LW'(gete_pkg::MAX_RESULTS))) begin
                  if (pend_ff) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.found     = 1'b1;
                     rsp_in.edge_src  = PB'(pend_src_ff);
                     rsp_in.edge_dest = PB'(pend_dest_ff);
                  end
                  pend_in      = 1'b1;
                  pend_src_in  = e_src;
                  pend_dest_in = e_dst;
                  list_n_in    = list_n_ff + LW'(1);
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- sv/graph_edge_table_engine.sv -----
// Directed-graph edge table. A request is taken when start is high and busy is low;
// busy rises only while the two-deep request queue is full. Every request scans the
// whole table once through an entry memory with one read port and one write port,
// one entry per cycle; the engine takes the next queued request only after the current
// one has given its final result. After reset a clearing pass writes every entry
// before the first request is worked; requests may be
// queued meanwhile. Results cannot be held off: each is on the rsp_ ports for one
// cycle, marked by rsp_valid. A listing sends its edges during the scan, one per
// match, and its final result with rsp_last set just after the scan ends; every
// other request gives one result right after its scan.
module graph_edge_table_engine #(
   parameter int ENTRIES  = gete_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = gete_pkg::KEY_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [gete_pkg::KIND_BITS-1:0]       req_kind,
   input  logic [gete_pkg::KEY_PORT_BITS-1:0]   req_src_key,
   input  logic [gete_pkg::KEY_PORT_BITS-1:0]   req_dest_key,
   output logic                                 rsp_valid,
   output logic [gete_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic                                 rsp_found,
   output logic [gete_pkg::COUNT_BITS-1:0]      rsp_count,
   output logic [gete_pkg::KEY_PORT_BITS-1:0]   rsp_edge_src,
   output logic [gete_pkg::KEY_PORT_BITS-1:0]   rsp_edge_dest,
   output logic                                 rsp_last
);

   logic               q_valid;
   logic               q_pop;
   gete_pkg::item_type q_item;
   gete_pkg::rsp_type  rsp;

   gete_front #(
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_src_key  (req_src_key),
      .req_dest_key (req_dest_key),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop)
   );

   gete_back #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_status    = rsp.status;
   assign rsp_found     = rsp.found;
   assign rsp_count     = rsp.count;
   assign rsp_edge_src  = rsp.edge_src;
   assign rsp_edge_dest = rsp.edge_dest;
   assign rsp_last      = rsp.last;

endmodule

// ----- tb/sv/graph_edge_table_engine_tb.sv -----
`timescale 1ns / 100ps

module graph_edge_table_engine_tb;
   import gete_pkg::*;

   localparam int ENTRIES      = ENTRIES_DEF;
   localparam int SCAN_CYCLES  = ENTRIES + 3;
   localparam int STALL_LIMIT  = 20 * SCAN_CYCLES;
   localparam int RANDOM_ITEMS = 55;
   localparam int QUIET_TAIL   = 15;
   localparam int POOL_SIZE    = 8;
   localparam int DIRECTED_N   = 25;

   // kinds the block treats as no-ops
   localparam logic [KIND_BITS-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_BITS-1:0] KIND_SPARE_B = 3'd7;

   typedef logic [KEY_PORT_BITS-1:0] key_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      key_type                src;
      key_type                dst;
      logic                   typed;
      logic [STATUS_BITS-1:0] status;
      logic                   found;
      logic [COUNT_BITS-1:0]  count;
   } step_row_type;

   bit   clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [KIND_BITS-1:0] req_kind = '0;
   key_type req_src_key  = '0;
   key_type req_dest_key = '0;
   logic busy;
   logic rsp_valid;
   logic [STATUS_BITS-1:0] rsp_status;
   logic rsp_found;
   logic [COUNT_BITS-1:0] rsp_count;
   key_type rsp_edge_src;
   key_type rsp_edge_dest;
   logic rsp_last;

   // shadow copy of the edge table
   bit      slot_used    [ENTRIES];
   bit      slot_is_edge [ENTRIES];
   key_type slot_src     [ENTRIES];
   key_type slot_dst     [ENTRIES];

   rsp_type rsp_due [$];
   key_type key_pool [POOL_SIZE];
   int      mismatches  = 0;
   int      quiet_cycles = 0;
   rsp_type seen_rsp;
   rsp_type due_rsp;

   step_row_type directed_ops [DIRECTED_N] = '{
      '{KIND_LIST,     16'h0000, 16'h0000, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_DEGREE,   16'hFFFF, 16'h0000, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_EXISTS,   16'h0000, 16'h0000, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_DEL_NODE, 16'h1234, 16'h0000, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_ADD_NODE, 16'hFFFF, 16'h0000, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_ADD_NODE, 16'hFFFF, 16'hFFFF, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_ADD_EDGE, 16'h0000, 16'hFFFF, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_ADD_EDGE, 16'h0000, 16'hFFFF, 1'b1, STATUS_DUP,  1'b0, 7'd0},
      '{KIND_ADD_EDGE, 16'hFFFF, 16'h0000, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_EXISTS,   16'h0000, 16'hFFFF, 1'b1, STATUS_OK,   1'b1, 7'd0},
      '{KIND_EXISTS,   16'hFFFF, 16'hFFFF, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_DEGREE,   16'h0000, 16'h0000, 1'b1, STATUS_OK,   1'b0, 7'd1},
      '{KIND_DEGREE,   16'hFFFF, 16'h0000, 1'b1, STATUS_OK,   1'b0, 7'd1},
      '{KIND_LIST,     16'hFFFF, 16'h0000, 1'b0, STATUS_OK,   1'b0, 7'd0},
      '{KIND_ADD_EDGE, 16'hAAAA, 16'h5555, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_ADD_EDGE, 16'h5555, 16'hAAAA, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_ADD_EDGE, 16'h5555, 16'h5555, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_LIST,     16'h5555, 16'h0000, 1'b0, STATUS_OK,   1'b0, 7'd0},
      '{KIND_SPARE_A,  16'h5555, 16'hAAAA, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_SPARE_B,  16'hFFFF, 16'hFFFF, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_DEL_NODE, 16'hFFFF, 16'h0000, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_EXISTS,   16'h0000, 16'hFFFF, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_LIST,     16'h0000, 16'h0000, 1'b0, STATUS_OK,   1'b0, 7'd0},
      '{KIND_DEL_NODE, 16'h5555, 16'h0000, 1'b1, STATUS_OK,   1'b0, 7'd0},
      '{KIND_DEGREE,   16'hAAAA, 16'h0000, 1'b1, STATUS_OK,   1'b0, 7'd0}
   };

   graph_edge_table_engine DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_src_key   (req_src_key),
      .req_dest_key  (req_dest_key),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_found     (rsp_found),
      .rsp_count     (rsp_count),
      .rsp_edge_src  (rsp_edge_src),
      .rsp_edge_dest (rsp_edge_dest),
      .rsp_last      (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int first_free_slot();
      for (int i = 0; i < ENTRIES; i++)
         if (!slot_used[i])
            return i;
      return -1;
   endfunction

   function automatic logic edge_stored(key_type s, key_type d);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_used[i] && slot_is_edge[i] && slot_src[i] == s && slot_dst[i] == d)
            return 1'b1;
      return 1'b0;
   endfunction

   // Append one result to the tail of the expected list.
   task automatic expect_rsp(input rsp_type r);
      rsp_due.insert(rsp_due.size(), r);
   endtask

   // Update the shadow table and queue the results the item should produce.
   task automatic table_apply(input logic [KIND_BITS-1:0] kind, input key_type s,
                              input key_type d);
      rsp_type r;
      int      slot;
      int      listed;
      r = '0;
      r.last = 1'b1;
      listed = 0;
      slot = first_free_slot();
      case (kind)
         KIND_ADD_NODE: begin
            if (slot < 0) begin
               r.status = STATUS_FULL;
            end else begin
               slot_used[slot]    = 1'b1;
               slot_is_edge[slot] = 1'b0;
               slot_src[slot]     = s;
            end
            expect_rsp(r);
         end
         KIND_ADD_EDGE: begin
            // an identical edge wins over a full table
            if (edge_stored(s, d)) begin
               r.status = STATUS_DUP;
            end else if (slot < 0) begin
               r.status = STATUS_FULL;
            end else begin
               slot_used[slot]    = 1'b1;
               slot_is_edge[slot] = 1'b1;
               slot_src[slot]     = s;
               slot_dst[slot]     = d;
            end
            expect_rsp(r);
         end
         KIND_DEL_NODE: begin
            for (int i = 0; i < ENTRIES; i++)
               if (slot_used[i] && (slot_src[i] == s || (slot_is_edge[i] && slot_dst[i] == s)))
                  slot_used[i] = 1'b0;
            expect_rsp(r);
         end
         KIND_DEGREE: begin
            for (int i = 0; i < ENTRIES; i++)
               if (slot_used[i] && slot_is_edge[i] && slot_src[i] == s && r.count < COUNT_MAX)
                  r.count = r.count + 1'b1;
            expect_rsp(r);
         end
         KIND_EXISTS: begin
            r.found = edge_stored(s, d);
            expect_rsp(r);
         end
         KIND_LIST: begin
            for (int i = 0; i < ENTRIES && listed < MAX_RESULTS; i++)
               if (slot_used[i] && slot_is_edge[i] && (slot_src[i] == s || slot_dst[i] == s)) begin
                  r = '0;
                  r.found     = 1'b1;
                  r.edge_src  = slot_src[i];
                  r.edge_dest = slot_dst[i];
                  expect_rsp(r);
                  listed++;
               end
            if (listed == 0) begin
               r = '0;
               r.last = 1'b1;
               expect_rsp(r);
            end else begin
               rsp_due[rsp_due.size() - 1].last = 1'b1;
            end
         end
         default: begin
            expect_rsp(r);
         end
      endcase
   endtask

   task automatic issue_req(input logic [KIND_BITS-1:0] kind, input key_type s, input key_type d);
      @(negedge clock);
      start        = 1'b1;
      req_kind     = kind;
      req_src_key  = s;
      req_dest_key = d;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      table_apply(kind, s, d);
   endtask

   task automatic rest_sender(input int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles - 1)
         @(negedge clock);
   endtask

   task automatic maybe_rest();
      if ($urandom_range(0, 3) == 0)
         rest_sender($urandom_range(1, 10));
   endtask

   // Drop start and hold until every queued result has come back.
   task automatic await_drain();
      @(negedge clock);
      start = 1'b0;
      while (rsp_due.size() != 0)
         @(posedge clock);
   endtask

   function automatic key_type random_key();
      if ($urandom_range(0, 99) < 85)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return key_type'($urandom);
   endfunction

   function automatic logic [KIND_BITS-1:0] pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)
         return KIND_ADD_EDGE;
      else if (roll < 45)
         return KIND_ADD_NODE;
      else if (roll < 53)
         return KIND_DEL_NODE;
      else if (roll < 65)
         return KIND_DEGREE;
      else if (roll < 80)
         return KIND_EXISTS;
      else if (roll < 97)
         return KIND_LIST;
      return roll[0] ? KIND_SPARE_A : KIND_SPARE_B;
   endfunction

   function automatic string rsp_text(rsp_type r);
      return $sformatf("status=%0d found=%0d count=%0d src=%h dest=%h last=%0d",
                       r.status, r.found, r.count, r.edge_src, r.edge_dest, r.last);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         seen_rsp.status    = rsp_status;
         seen_rsp.found     = rsp_found;
         seen_rsp.count     = rsp_count;
         seen_rsp.edge_src  = rsp_edge_src;
         seen_rsp.edge_dest = rsp_edge_dest;
         seen_rsp.last      = rsp_last;
         if (rsp_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, got %s", $time, rsp_text(seen_rsp));
            mismatches++;
         end else begin
            due_rsp = rsp_due.pop_front();
            if (seen_rsp !== due_rsp) begin
               $display("%0t: result mismatch: expected %s, got %s",
                        $time, rsp_text(due_rsp), rsp_text(seen_rsp));
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("graph_edge_table_engine_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      step_row_type row;
      rsp_type      typed_rsp;
      key_type      hub;
      key_type      spoke;
      key_type      first_spoke;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = key_type'($urandom);
      repeat (5)
         @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_ops[i]) begin
         row = directed_ops[i];
         maybe_rest();
         issue_req(row.kind, row.src, row.dst);
         if (row.typed) begin
            void'(rsp_due.pop_back());
            typed_rsp        = '0;
            typed_rsp.status = row.status;
            typed_rsp.found  = row.found;
            typed_rsp.count  = row.count;
            typed_rsp.last   = 1'b1;
            expect_rsp(typed_rsp);
         end
      end
      await_drain();

      // Fill the empty table with edges around one hub, half in and half out.
      hub = {1'b1, 15'($urandom)};
      first_spoke = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         spoke = {1'b0, 9'($urandom), 6'(i)};
         if (i == 0)
            first_spoke = spoke;
         maybe_rest();
         if (i[0])
            issue_req(KIND_ADD_EDGE, spoke, hub);
         else
            issue_req(KIND_ADD_EDGE, hub, spoke);
      end
      issue_req(KIND_ADD_EDGE, hub, key_type'($urandom));
      issue_req(KIND_ADD_NODE, key_type'($urandom), '0);
      issue_req(KIND_ADD_EDGE, hub, first_spoke);
      issue_req(KIND_DEGREE, hub, '0);
      issue_req(KIND_LIST, hub, '0);
      issue_req(KIND_DEL_NODE, hub, '0);
      await_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2)
            await_drain();
         if (n < RANDOM_ITEMS - QUIET_TAIL)
            maybe_rest();
         issue_req(pick_kind(), random_key(), random_key());
      end
      await_drain();
      repeat (2 * SCAN_CYCLES)
         @(posedge clock);

      if (mismatches == 0)
         $display("graph_edge_table_engine_tb: PASS");
      else
         $display("graph_edge_table_engine_tb: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/gete_pkg.sv
sv/gete_front.sv
sv/gete_back.sv
sv/graph_edge_table_engine.sv
tb/sv/graph_edge_table_engine_tb.sv
